// File: design/rwc_pkg.sv
// Shared types and codes for the route waypoint cursor.
// Used by the front decoder, the item queue, the back end and the top level.
package rwc_pkg;

    localparam int COORD_W       = 24;
    localparam int IDX_W         = 10;
    localparam int LEN_W         = 11;
    localparam int MAX_WAYPOINTS = 1024;

    // Command codes as they arrive on the input channel.
    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_NEAR   = 3'd1;
    localparam logic [2:0] CMD_TRACK  = 3'd2;
    localparam logic [2:0] CMD_SEED   = 3'd3;
    localparam logic [2:0] CMD_SELECT = 3'd4;

    // Internal operation classes after decoding.
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_NEAR   = 3'd2;
    localparam logic [2:0] OP_TRACK  = 3'd3;
    localparam logic [2:0] OP_SEED   = 3'd4;
    localparam logic [2:0] OP_SELECT = 3'd5;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_RANGE    = 2'd1;
    localparam logic [1:0] STAT_ZERO_SPC = 2'd2;
    localparam logic [1:0] STAT_OVF      = 2'd3;

    typedef struct packed {
        logic [2:0]               cmd;
        logic [IDX_W-1:0]         sample_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [31:0]       speed;
        logic signed [31:0]       spacing;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0] current_index;
        logic [IDX_W-1:0] lookahead_index;
        logic [1:0]       status;
    } t_out;

    typedef struct packed {
        logic [2:0]               op;
        logic [IDX_W-1:0]         sample_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_z;
        logic [31:0]              speed_mag;
        logic [31:0]              spacing_mag;
        logic                     spacing_neg;
        logic                     spacing_zero;
    } t_job;

endpackage

// File: design/route_waypoint_cursor.sv
// Top level of the route waypoint cursor: front decoder, item queue, back end.
// Depends on rwc_pkg, rwc_front, rwc_queue and rwc_back.
//
//  Channel  | Signals                            | Direction
//  ---------+------------------------------------+----------
//  input    | i_in_valid, o_in_stall, i_in_item  | in
//  result   | o_out_valid, i_out_stall, o_out_item | out
//  config   | i_cfg_we, i_cfg_wdata              | in
//
// Load, select and unused commands go straight to the result register. Reset-nearest
// reads one waypoint per cycle through the memory port and the three-stage distance
// pipeline. Track probes the current waypoint and then its neighbours, up to 2L + 1
// probes. Seed runs in the one-bit-a-cycle divider.
// Reset is synchronous; the queue holds two items so input is taken while a result
// waits on a stalled output.
module route_waypoint_cursor #(
    parameter int MAX_WAYPOINTS = rwc_pkg::MAX_WAYPOINTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rwc_pkg::LEN_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  rwc_pkg::t_in              i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output rwc_pkg::t_out             o_out_item
);

    rwc_pkg::t_job w_dec_job;
    rwc_pkg::t_job w_q_job;
    logic          w_push;
    logic          w_pop;
    logic          w_q_valid;
    logic          w_q_full;

    rwc_front u_front (
        .i_item (i_in_item),
        .o_job  (w_dec_job)
    );

    assign o_in_stall = w_q_full;
    assign w_push     = i_in_valid && !w_q_full;

    rwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_dec_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_job   (w_q_job)
    );

    rwc_back #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_job),
        .o_job_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("back end took an item from an empty queue");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

    a_pop_needs_free_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !o_out_valid)
        else $error("new item started while a result was still held");

endmodule

// File: design/rwc_front.sv
// Front decoder: classifies an incoming item into an operation and prepares
// the magnitudes used by the lookahead seed. Depends on rwc_pkg.
module rwc_front (
    input  rwc_pkg::t_in  i_item,
    output rwc_pkg::t_job o_job
);

    logic [2:0] w_op;

    always_comb begin
        case (i_item.cmd)
            rwc_pkg::CMD_LOAD:   w_op = rwc_pkg::OP_LOAD;
            rwc_pkg::CMD_NEAR:   w_op = rwc_pkg::OP_NEAR;
            rwc_pkg::CMD_TRACK:  w_op = rwc_pkg::OP_TRACK;
            rwc_pkg::CMD_SEED:   w_op = rwc_pkg::OP_SEED;
            rwc_pkg::CMD_SELECT: w_op = rwc_pkg::OP_SELECT;
            default:             w_op = rwc_pkg::OP_NOP;
        endcase
    end

    // Negating the most negative value wraps to the right unsigned magnitude.
    always_comb begin
        o_job.op           = w_op;
        o_job.sample_index = i_item.sample_index;
        o_job.pos_x        = i_item.pos_x;
        o_job.pos_z        = i_item.pos_z;
        o_job.speed_mag    = i_item.speed[31] ? 32'(-i_item.speed) : 32'(i_item.speed);
        o_job.spacing_mag  = i_item.spacing[31] ? 32'(-i_item.spacing)
                                                : 32'(i_item.spacing);
        o_job.spacing_neg  = i_item.spacing[31];
        o_job.spacing_zero = (i_item.spacing == 32'sd0);
    end

endmodule

// File: design/rwc_queue.sv
// Two-entry queue of decoded items between the front decoder and the back end.
// Depends on rwc_pkg for the item type.
module rwc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rwc_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output rwc_pkg::t_job o_job
);

    rwc_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: design/rwc_back.sv
// Back end: waypoint memory, squared-distance pipeline, nearest search,
// track walk, serial divider for the lookahead seed and the result register.
// Depends on rwc_pkg.
module rwc_back #(
    parameter int MAX_WAYPOINTS = rwc_pkg::MAX_WAYPOINTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rwc_pkg::LEN_W-1:0] i_cfg_wdata,
    input  logic                      i_job_valid,
    input  rwc_pkg::t_job             i_job,
    output logic                      o_job_pop,
    output logic                      o_out_valid,
    output rwc_pkg::t_out             o_out_item,
    input  logic                      i_out_stall
);

    localparam int IW  = $clog2(MAX_WAYPOINTS);
    localparam int LW  = $clog2(MAX_WAYPOINTS + 1);
    localparam int CW  = rwc_pkg::COORD_W;
    localparam int SQW = 2 * (CW + 1);
    localparam int DW  = SQW + 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_NEAR  = 4'd1;
    localparam logic [3:0] ST_TRACK = 4'd2;
    localparam logic [3:0] ST_SQ    = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_CHK   = 4'd5;
    localparam logic [3:0] ST_MOD   = 4'd6;
    localparam logic [3:0] ST_APPLY = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    localparam logic [1:0] PH_CUR = 2'd0;
    localparam logic [1:0] PH_FWD = 2'd1;
    localparam logic [1:0] PH_BWD = 2'd2;

    logic signed [CW-1:0] mem_x [MAX_WAYPOINTS];
    logic signed [CW-1:0] mem_z [MAX_WAYPOINTS];

    logic [rwc_pkg::LEN_W-1:0] r_route;
    logic [3:0]                r_st;
    logic [IW-1:0]             r_cur;
    logic [IW-1:0]             r_look;
    logic [1:0]                r_stat;
    rwc_pkg::t_job             r_job;
    logic                      r_out_vld;
    rwc_pkg::t_out             r_out;

    logic                 r_iss_vld;
    logic [IW-1:0]        r_iss_idx;
    logic                 r_p1_vld;
    logic [IW-1:0]        r_p1_idx;
    logic signed [CW-1:0] r_wx;
    logic signed [CW-1:0] r_wz;
    logic                 r_p2_vld;
    logic [IW-1:0]        r_p2_idx;
    logic [SQW-1:0]       r_sqx;
    logic [SQW-1:0]       r_sqz;
    logic                 r_p3_vld;
    logic [IW-1:0]        r_p3_idx;
    logic [DW-1:0]        r_d;

    logic [LW-1:0] r_nxt;
    logic [IW-1:0] r_best;
    logic [DW-1:0] r_bd;
    logic [DW-1:0] r_cd;
    logic [1:0]    r_ph;
    logic [LW-1:0] r_cnt;

    logic [63:0] r_dq;
    logic [63:0] r_rm;
    logic [63:0] r_dv;
    logic [5:0]  r_dcnt;

    logic [31:0]   w_len32;
    logic [LW-1:0] w_len;
    logic          w_start;
    logic          w_bad_cur;
    logic          w_we;
    logic [CW:0]   w_dx;
    logic [CW:0]   w_dz;
    logic [CW:0]   w_ax;
    logic [CW:0]   w_az;
    logic          w_take;
    logic [IW-1:0] w_best_n;
    logic          w_less;
    logic          w_step_end;
    logic [63:0]   w_t;
    logic          w_ge;
    logic [31:0]   w_r32;
    logic [31:0]   w_sum32;
    logic [31:0]   w_look32;

    function automatic logic [IW-1:0] f_succ(input logic [IW-1:0] c, input logic [LW-1:0] n);
        return (32'(c) + 32'd1 == 32'(n)) ? IW'(0) : IW'(32'(c) + 32'd1);
    endfunction

    function automatic logic [IW-1:0] f_pred(input logic [IW-1:0] c, input logic [LW-1:0] n);
        return (c == IW'(0)) ? IW'(32'(n) - 32'd1) : IW'(32'(c) - 32'd1);
    endfunction

    function automatic logic [rwc_pkg::IDX_W-1:0] f_to_out(input logic [IW-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        return t[rwc_pkg::IDX_W-1:0];
    endfunction

    assign w_len32 = (32'(r_route) > 32'(MAX_WAYPOINTS)) ? 32'(MAX_WAYPOINTS)
                                                          : 32'(r_route);
    assign w_len     = w_len32[LW-1:0];
    assign w_start   = (r_st == ST_IDLE) && i_job_valid && !r_out_vld;
    assign o_job_pop = w_start;
    assign w_bad_cur = (w_len == LW'(0)) || (32'(r_cur) >= 32'(w_len));
    assign w_we      = w_start && (i_job.op == rwc_pkg::OP_LOAD)
                       && (32'(i_job.sample_index) < 32'(MAX_WAYPOINTS));

    // Distance pipeline: read, square, sum.
    assign w_dx = {r_job.pos_x[CW-1], r_job.pos_x} - {r_wx[CW-1], r_wx};
    assign w_dz = {r_job.pos_z[CW-1], r_job.pos_z} - {r_wz[CW-1], r_wz};
    assign w_ax = w_dx[CW] ? -w_dx : w_dx;
    assign w_az = w_dz[CW] ? -w_dz : w_dz;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_x[IW'(i_job.sample_index)] <= i_job.pos_x;
            mem_z[IW'(i_job.sample_index)] <= i_job.pos_z;
        end
        r_wx <= mem_x[r_iss_idx];
        r_wz <= mem_z[r_iss_idx];
    end

    always_ff @(posedge i_clk) begin
        r_p1_idx <= r_iss_idx;
        r_sqx    <= SQW'(w_ax) * SQW'(w_ax);
        r_sqz    <= SQW'(w_az) * SQW'(w_az);
        r_p2_idx <= r_p1_idx;
        r_d      <= DW'(r_sqx) + DW'(r_sqz);
        r_p3_idx <= r_p2_idx;
    end

    // Nearest search keeps the lowest index among equal minima.
    assign w_take   = (r_p3_idx == IW'(0)) || (r_d < r_bd);
    assign w_best_n = w_take ? r_p3_idx : r_best;
    assign w_less   = r_d < r_cd;
    assign w_step_end = (32'(r_cnt) + 32'd1 == 32'(w_len));

    // Restoring divider step, shared by quotient and remainder passes.
    assign w_t  = {r_rm[62:0], r_dq[63]};
    assign w_ge = (w_t >= r_dv);

    assign w_r32    = 32'(r_rm[LW-1:0]);
    assign w_sum32  = r_job.spacing_neg ? (32'(r_cur) + w_r32)
                                        : (32'(r_cur) + 32'(w_len) - w_r32);
    assign w_look32 = (w_sum32 >= 32'(w_len)) ? (w_sum32 - 32'(w_len)) : w_sum32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route   <= '0;
            r_st      <= ST_IDLE;
            r_cur     <= '0;
            r_look    <= '0;
            r_out_vld <= 1'b0;
            r_iss_vld <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_route <= i_cfg_wdata;
            end
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            r_p1_vld  <= r_iss_vld;
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_iss_vld <= 1'b0;

            case (r_st)
                ST_IDLE: begin
                    if (w_start) begin
                        r_job  <= i_job;
                        r_stat <= rwc_pkg::STAT_OK;
                        r_st   <= ST_FIN;
                        case (i_job.op)
                            rwc_pkg::OP_LOAD: begin
                                if (32'(i_job.sample_index) >= 32'(MAX_WAYPOINTS)) begin
                                    r_stat <= rwc_pkg::STAT_RANGE;
                                end
                            end
                            rwc_pkg::OP_SELECT: begin
                                if (32'(i_job.sample_index) >= 32'(w_len)) begin
                                    r_stat <= rwc_pkg::STAT_RANGE;
                                end else begin
                                    r_look <= IW'(i_job.sample_index);
                                end
                            end
                            rwc_pkg::OP_NEAR: begin
                                if (w_len == LW'(0)) begin
                                    r_stat <= rwc_pkg::STAT_RANGE;
                                end else begin
                                    r_nxt <= '0;
                                    r_st  <= ST_NEAR;
                                end
                            end
                            rwc_pkg::OP_TRACK: begin
                                if (w_bad_cur) begin
                                    r_stat <= rwc_pkg::STAT_RANGE;
                                end else begin
                                    r_iss_vld <= 1'b1;
                                    r_iss_idx <= r_cur;
                                    r_ph      <= PH_CUR;
                                    r_st      <= ST_TRACK;
                                end
                            end
                            rwc_pkg::OP_SEED: begin
                                if (w_bad_cur) begin
                                    r_stat <= rwc_pkg::STAT_RANGE;
                                end else if (i_job.spacing_zero) begin
                                    r_stat <= rwc_pkg::STAT_ZERO_SPC;
                                end else begin
                                    r_st <= ST_SQ;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                ST_NEAR: begin
                    if (r_nxt != w_len) begin
                        r_iss_vld <= 1'b1;
                        r_iss_idx <= r_nxt[IW-1:0];
                        r_nxt     <= r_nxt + LW'(1);
                    end
                    if (r_p3_vld) begin
                        if (w_take) begin
                            r_bd <= r_d;
                        end
                        r_best <= w_best_n;
                        if (32'(r_p3_idx) + 32'd1 == 32'(w_len)) begin
                            r_cur  <= w_best_n;
                            r_look <= w_best_n;
                            r_st   <= ST_FIN;
                        end
                    end
                end

                ST_TRACK: begin
                    if (r_p3_vld) begin
                        case (r_ph)
                            PH_CUR: begin
                                r_cd      <= r_d;
                                r_ph      <= PH_FWD;
                                r_cnt     <= '0;
                                r_iss_vld <= 1'b1;
                                r_iss_idx <= f_succ(r_cur, w_len);
                            end
                            PH_FWD: begin
                                r_iss_vld <= 1'b1;
                                if (w_less) begin
                                    r_cur <= r_p3_idx;
                                    if (r_look == r_cur) begin
                                        r_look <= r_p3_idx;
                                    end
                                    r_cd <= r_d;
                                    if (w_step_end) begin
                                        r_ph      <= PH_BWD;
                                        r_cnt     <= '0;
                                        r_iss_idx <= f_pred(r_p3_idx, w_len);
                                    end else begin
                                        r_cnt     <= r_cnt + LW'(1);
                                        r_iss_idx <= f_succ(r_p3_idx, w_len);
                                    end
                                end else begin
                                    r_ph      <= PH_BWD;
                                    r_cnt     <= '0;
                                    r_iss_idx <= f_pred(r_cur, w_len);
                                end
                            end
                            default: begin
                                if (w_less) begin
                                    r_cur <= r_p3_idx;
                                    if (r_look == r_cur) begin
                                        r_look <= r_p3_idx;
                                    end
                                    r_cd <= r_d;
                                    if (w_step_end) begin
                                        r_st <= ST_FIN;
                                    end else begin
                                        r_cnt     <= r_cnt + LW'(1);
                                        r_iss_vld <= 1'b1;
                                        r_iss_idx <= f_pred(r_p3_idx, w_len);
                                    end
                                end else begin
                                    r_st <= ST_FIN;
                                end
                            end
                        endcase
                    end
                end

                ST_SQ: begin
                    r_dq   <= r_job.speed_mag * r_job.speed_mag;
                    r_dv   <= {15'd0, r_job.spacing_mag, 17'd0};
                    r_rm   <= '0;
                    r_dcnt <= '0;
                    r_st   <= ST_DIV;
                end

                ST_DIV, ST_MOD: begin
                    r_rm   <= w_ge ? (w_t - r_dv) : w_t;
                    r_dq   <= {r_dq[62:0], w_ge};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd63) begin
                        r_st <= (r_st == ST_DIV) ? ST_CHK : ST_APPLY;
                    end
                end

                ST_CHK: begin
                    // A negative spacing allows a quotient one larger before overflow.
                    if (r_job.spacing_neg ? (r_dq > 64'd2147483648)
                                          : (r_dq > 64'd2147483647)) begin
                        r_stat <= rwc_pkg::STAT_OVF;
                        r_st   <= ST_FIN;
                    end else begin
                        r_dv   <= 64'(w_len);
                        r_rm   <= '0;
                        r_dcnt <= '0;
                        r_st   <= ST_MOD;
                    end
                end

                ST_APPLY: begin
                    r_look <= IW'(w_look32);
                    r_st   <= ST_FIN;
                end

                ST_FIN: begin
                    r_out_vld             <= 1'b1;
                    r_out.current_index   <= f_to_out(r_cur);
                    r_out.lookahead_index <= f_to_out(r_look);
                    r_out.status          <= r_stat;
                    r_st                  <= ST_IDLE;
                end

                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// File: tb/rwc_checker.sv
// Checker for the route waypoint cursor: watches the config port and both channels,
// predicts each result from its own copy of the route and indices, and counts errors.
// Depends on rwc_pkg.
`timescale 1ns / 1ps
module rwc_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rwc_pkg::LEN_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  rwc_pkg::t_in              i_in_item,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  rwc_pkg::t_out             i_out_item,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_results
);
    import rwc_pkg::*;

    logic signed [COORD_W-1:0] route_x [MAX_WAYPOINTS];
    logic signed [COORD_W-1:0] route_z [MAX_WAYPOINTS];
    int            cur_wp;
    int            look_wp;
    logic [LEN_W-1:0] len_reg;
    t_out          cursor_q[$];

    function automatic longint unsigned sq_dist(int i, logic signed [COORD_W-1:0] px,
                                                logic signed [COORD_W-1:0] pz);
        longint dx;
        longint dz;
        dx = longint'(px) - longint'(route_x[i]);
        dz = longint'(pz) - longint'(route_z[i]);
        return longint'(dx * dx) + longint'(dz * dz);
    endfunction

    function automatic logic [1:0] walk_route(int len, logic signed [COORD_W-1:0] px,
                                             logic signed [COORD_W-1:0] pz);
        longint unsigned cd;
        longint unsigned d;
        int nxt;
        int prev;
        if (len == 0 || cur_wp >= len) return STAT_RANGE;
        cd = sq_dist(cur_wp, px, pz);
        for (int s = 0; s < len; s++) begin
            nxt = (cur_wp + 1 == len) ? 0 : cur_wp + 1;
            d = sq_dist(nxt, px, pz);
            if (d >= cd) break;
            prev = cur_wp;
            cur_wp = nxt;
            if (look_wp == prev) look_wp = cur_wp;
            cd = d;
        end
        for (int s = 0; s < len; s++) begin
            nxt = (cur_wp == 0) ? len - 1 : cur_wp - 1;
            d = sq_dist(nxt, px, pz);
            if (d >= cd) break;
            prev = cur_wp;
            cur_wp = nxt;
            if (look_wp == prev) look_wp = cur_wp;
            cd = d;
        end
        return STAT_OK;
    endfunction

    function automatic logic [1:0] seed_lookahead(int len, logic signed [31:0] sp,
                                                 logic signed [31:0] spc);
        longint unsigned as_mag;
        longint unsigned ap_mag;
        longint unsigned q;
        longint unsigned r;
        if (len == 0 || cur_wp >= len) return STAT_RANGE;
        if (spc == 0) return STAT_ZERO_SPC;
        as_mag = sp < 0 ? longint'(-longint'(sp)) : longint'(sp);
        ap_mag = spc < 0 ? longint'(-longint'(spc)) : longint'(spc);
        q = (as_mag * as_mag) / (ap_mag << 17);
        if (spc > 0 ? q > 64'd2147483647 : q > 64'd2147483648) return STAT_OVF;
        r = q % len;
        if (spc > 0) look_wp = int'((longint'(cur_wp) + len - r) % len);
        else         look_wp = int'((longint'(cur_wp) + r) % len);
        return STAT_OK;
    endfunction

    function automatic t_out predict_cursor(t_in it);
        t_out res;
        int len;
        int best;
        longint unsigned bd;
        longint unsigned d;
        len = (len_reg > MAX_WAYPOINTS) ? MAX_WAYPOINTS : int'(len_reg);
        res.status = STAT_OK;
        case (it.cmd)
            CMD_LOAD: begin
                route_x[it.sample_index] = it.pos_x;
                route_z[it.sample_index] = it.pos_z;
            end
            CMD_NEAR: begin
                if (len == 0) begin
                    res.status = STAT_RANGE;
                end else begin
                    best = 0;
                    bd = sq_dist(0, it.pos_x, it.pos_z);
                    for (int i = 1; i < len; i++) begin
                        d = sq_dist(i, it.pos_x, it.pos_z);
                        if (d < bd) begin
                            bd = d;
                            best = i;
                        end
                    end
                    cur_wp = best;
                    look_wp = best;
                end
            end
            CMD_TRACK: res.status = walk_route(len, it.pos_x, it.pos_z);
            CMD_SEED:  res.status = seed_lookahead(len, it.speed, it.spacing);
            CMD_SELECT: begin
                if (int'(it.sample_index) >= len) res.status = STAT_RANGE;
                else look_wp = it.sample_index;
            end
            default: ;
        endcase
        res.current_index = cur_wp[IDX_W-1:0];
        res.lookahead_index = look_wp[IDX_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            cur_wp = 0;
            look_wp = 0;
            len_reg = '0;
            cursor_q.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we) len_reg = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) cursor_q.push_back(predict_cursor(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (cursor_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: result with nothing expected: cur %0d look %0d st %0d",
                                 $realtime, i_out_item.current_index,
                                 i_out_item.lookahead_index, i_out_item.status);
                    o_errors <= o_errors + 1;
                end else begin
                    want = cursor_q.pop_front();
                    if (want !== i_out_item) begin
                        if (o_errors < 10)
                            $display("%0t: mismatch: expected cur %0d look %0d st %0d, got cur %0d look %0d st %0d",
                                     $realtime, want.current_index, want.lookahead_index,
                                     want.status, i_out_item.current_index,
                                     i_out_item.lookahead_index, i_out_item.status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= cursor_q.size();
    end

endmodule

// File: tb/tb_route_waypoint_cursor.sv
// Testbench top for the route waypoint cursor: clock, reset, stimulus and verdict.
// Depends on rwc_pkg, route_waypoint_cursor and rwc_checker.
`timescale 1ns / 1ps
module tb_route_waypoint_cursor;
    import rwc_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [LEN_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in              i_in_item = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out             o_out_item;
    int               errors;
    int               pending;
    int               results;

    bit               loaded [MAX_WAYPOINTS];
    int               route_len = 0;
    int               items_sent = 0;
    int               stall_left = 0;
    bit               quiet = 1'b0;

    always #2 i_clk = ~i_clk;

    route_waypoint_cursor uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );

    rwc_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_item(i_in_item),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_item(o_out_item),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Result side: a stall of random length after each result taken, none in quiet stretches.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            if (o_out_valid) stall_left = quiet ? 0 : $urandom_range(0, 17);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(t_in it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (it.cmd == CMD_LOAD) loaded[it.sample_index] = 1'b1;
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_route_len(logic [LEN_W-1:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        route_len = (v > MAX_WAYPOINTS) ? MAX_WAYPOINTS : int'(v);
    endtask

    function automatic t_in make_item(logic [2:0] c, int idx, int x, int z,
                                      int sp, int spc);
        t_in it;
        it.cmd = c;
        it.sample_index = idx[IDX_W-1:0];
        it.pos_x = x[COORD_W-1:0];
        it.pos_z = z[COORD_W-1:0];
        it.speed = sp;
        it.spacing = spc;
        return it;
    endfunction

    // Nearest and track read waypoints 0..L-1, so those must all have been loaded.
    function automatic int first_unloaded();
        for (int i = 0; i < route_len; i++) if (!loaded[i]) return i;
        return -1;
    endfunction

    function automatic t_in random_item();
        t_in it;
        int pick;
        int hole;
        it = t_in'({$urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        // Mostly positions within +-2000 on each axis, sometimes full-range noise.
        if (pick % 5 != 0) begin
            it.pos_x = $urandom_range(0, 4000) - 2000;
            it.pos_z = $urandom_range(0, 4000) - 2000;
        end
        if (pick < 20) begin
            it.cmd = CMD_LOAD;
            if (pick < 15) it.sample_index = $urandom_range(0, (route_len > 0 && route_len < 64)
                                                             ? route_len + 2 : 70);
        end else if (pick < 35) it.cmd = CMD_NEAR;
        else if (pick < 68) it.cmd = CMD_TRACK;
        else if (pick < 83) begin
            it.cmd = CMD_SEED;
            case ($urandom_range(0, 3))
                0: begin
                    it.speed = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
                    it.spacing = $signed($urandom_range(1, 1 << 18)) - (1 << 17);
                end
                1: it.spacing = $urandom_range(0, 1) ? 0 : it.spacing;
                default: ;
            endcase
        end else if (pick < 95) begin
            it.cmd = CMD_SELECT;
            if (pick < 92) it.sample_index = $urandom_range(0, route_len + 3);
        end else it.cmd = 3'($urandom_range(5, 7));
        hole = first_unloaded();
        if ((it.cmd == CMD_NEAR || it.cmd == CMD_TRACK) && hole >= 0) begin
            it.cmd = CMD_LOAD;
            it.sample_index = hole;
        end
        return it;
    endfunction

    initial begin
        int lens [10] = '{2047, 1, 2, 3, 7, 16, 33, 64, 1024, 5};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty route: every command but load refuses, unused codes do nothing.
        send_item(make_item(CMD_NEAR, 0, 0, 0, 0, 1));
        send_item(make_item(CMD_TRACK, 0, 0, 0, 0, 1));
        send_item(make_item(CMD_SEED, 0, 0, 0, 65536, 65536));
        send_item(make_item(CMD_SELECT, 0, 0, 0, 0, 0));
        send_item(make_item(3'd5, 1023, 0, 0, 0, 0));
        send_item(make_item(3'd7, 0, 0, 0, 0, 0));
        // Coordinate extremes, and a tie between entries 1 and 3.
        send_item(make_item(CMD_LOAD, 0, 8388607, 8388607, 0, 0));
        send_item(make_item(CMD_LOAD, 1, 100, 100, 0, 0));
        send_item(make_item(CMD_LOAD, 2, -8388608, -8388608, 0, 0));
        send_item(make_item(CMD_LOAD, 3, 100, 100, 0, 0));
        send_item(make_item(CMD_LOAD, 1023, -1, 8388607, 0, 0));
        set_route_len(4);
        send_item(make_item(CMD_NEAR, 0, 100, 100, 0, 0));
        send_item(make_item(CMD_TRACK, 0, -8388608, -8388608, 0, 0));
        send_item(make_item(CMD_TRACK, 0, 8388607, 8388607, 0, 0));
        send_item(make_item(CMD_SELECT, 3, 0, 0, 0, 0));
        send_item(make_item(CMD_SELECT, 4, 0, 0, 0, 0));
        send_item(make_item(CMD_SEED, 0, 0, 0, 65536, 0));
        send_item(make_item(CMD_SEED, 0, 0, 0, 32'h8000_0000, 1));
        send_item(make_item(CMD_SEED, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
        send_item(make_item(CMD_SEED, 0, 0, 0, 1 << 20, -(1 << 16)));
        send_item(make_item(CMD_SEED, 0, 0, 0, 1 << 20, 1 << 16));
        set_route_len(0);
        send_item(make_item(CMD_SELECT, 0, 0, 0, 0, 0));

        foreach (lens[p]) begin
            set_route_len(lens[p]);
            for (int n = 0; n < 58; n++) begin
                if (n % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
                if (p == 4 && n == 30) drain();
                send_item(random_item());
            end
            quiet = 1'b0;
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        $display("Sent %0d items over %0d route lengths (empty, saturated, 1 to 1024);",
                 items_sent, 13);
        $display("checked %0d results, %0d errors.", results, errors);
        if (errors == 0) begin
            $display("[route_waypoint_cursor] OK");
        end else begin
            $display("[route_waypoint_cursor] ERROR");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Timed out with %0d results still expected.", pending);
        $display("[route_waypoint_cursor] ERROR");
        $finish;
    end

endmodule
